### src/pfc_pkg.sv
// ----------------------------------------------------------------------------
// Playfair cipher stream package
// Shared constants, command codes, memory request and status types, and the
// small grid arithmetic helpers used by the controller.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int LETTER_W   = 5;
  localparam int CELL_W     = 5;
  localparam int GRID_CELLS = 25;
  localparam int ALPHABET   = 26;

  localparam logic [LETTER_W-1:0] LETTER_I      = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J      = 5'd9;
  localparam logic [LETTER_W-1:0] LETTER_X      = 5'd23;
  localparam logic [LETTER_W-1:0] LETTER_LAST   = 5'd25;
  localparam logic [LETTER_W-1:0] ALPHABET_SIZE = 5'd26;
  localparam logic [CELL_W-1:0]   CELLS_FULL    = 5'd25;

  typedef enum logic [1:0] {
    CMD_BEGIN_KEY  = 2'd0,
    CMD_KEY_LETTER = 2'd1,
    CMD_KEY_END    = 2'd2,
    CMD_TEXT       = 2'd3
  } cmd_t;

  typedef struct packed {
    logic        we;
    logic [4:0]  waddr;
    logic [4:0]  wdata;
    logic        re;
    logic [4:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic              busy;
    logic              held_valid;
    logic [CELL_W-1:0] fill;
  } pfc_status_t;

  function automatic logic [2:0] row_of(input logic [CELL_W-1:0] p);
    logic [2:0] r;
    if (p < 5'd5) begin
      r = 3'd0;
    end else if (p < 5'd10) begin
      r = 3'd1;
    end else if (p < 5'd15) begin
      r = 3'd2;
    end else if (p < 5'd20) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

  function automatic logic [CELL_W-1:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic logic [2:0] col_of(input logic [CELL_W-1:0] p, input logic [2:0] r);
    logic [CELL_W-1:0] t;
    t = p - cell_of(r, 3'd0);
    return t[2:0];
  endfunction

  function automatic logic [2:0] add_mod5(input logic [2:0] c, input logic [2:0] sh);
    logic [3:0] s;
    s = {1'b0, c} + {1'b0, sh};
    if (s >= 4'd5) begin
      s = s - 4'd5;
    end
    return s[2:0];
  endfunction

endpackage

### src/pfc_in_if.sv
// ----------------------------------------------------------------------------
// Playfair input channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface pfc_in_if import pfc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [LETTER_W-1:0] letter;
  logic                last_letter;

  modport source(output valid, output command, output letter, output last_letter,
                 input ready);
  modport sink(input valid, input command, input letter, input last_letter,
               output ready);
endinterface

### src/pfc_out_if.sv
// ----------------------------------------------------------------------------
// Playfair output channel
// Valid/ready channel that carries one result letter item.
// ----------------------------------------------------------------------------
interface pfc_out_if import pfc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] out_letter;
  logic                run_end;

  modport source(output valid, output out_letter, output run_end, input ready);
  modport sink(input valid, input out_letter, input run_end, output ready);
endinterface

### src/pfc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module pfc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### src/pfc_ctrl.sv
// ----------------------------------------------------------------------------
// Playfair controller
// Key loading, digraph forming and the lookup sequence over the key grid
// and letter place memories, with the result register.
// ----------------------------------------------------------------------------
module pfc_ctrl import pfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_data,
  pfc_in_if.sink            text_in,
  pfc_out_if.source         text_out,
  output ram_req_t          grid_req,
  input  logic [LETTER_W-1:0] grid_rdata,
  output ram_req_t          place_req,
  input  logic [CELL_W-1:0] place_rdata,
  output pfc_status_t       status
);
  typedef enum logic [2:0] {
    S_IDLE, S_KEY, S_PA, S_PB, S_GA, S_OA, S_OB
  } state_t;

  state_t                state;
  logic                  decrypt;
  logic [ALPHABET-1:0]   used;
  logic [CELL_W-1:0]     fill;
  logic [LETTER_W-1:0]   held_letter;
  logic                  held_valid;
  logic [LETTER_W-1:0]   walk;
  logic [LETTER_W-1:0]   pair_a;
  logic [LETTER_W-1:0]   pair_b;
  logic                  second;
  logic [LETTER_W-1:0]   second_letter;
  logic [CELL_W-1:0]     pa;
  logic [CELL_W-1:0]     gb;
  logic [LETTER_W-1:0]   out_letter;
  logic                  out_run_end;
  logic                  out_valid;

  logic                  fire;
  cmd_t                  cmd;
  logic [LETTER_W-1:0]   lt;
  logic                  lt_ok;
  logic                  place_active;
  logic [LETTER_W-1:0]   place_ch;
  logic                  place_hit;
  logic                  place_do;
  logic                  slot_free;
  logic [2:0]            sh;
  logic [2:0]            ra, ca, rb, cb;
  logic [CELL_W-1:0]     ga_c, gb_c;

  assign fire  = text_in.valid && text_in.ready;
  assign cmd   = cmd_t'(text_in.command);
  assign lt    = (text_in.letter == LETTER_J) ? LETTER_I : text_in.letter;
  assign lt_ok = lt < ALPHABET_SIZE;

  assign text_in.ready       = (state == S_IDLE);
  assign text_out.valid      = out_valid;
  assign text_out.out_letter = out_letter;
  assign text_out.run_end    = out_run_end;
  assign slot_free           = !out_valid || text_out.ready;

  assign status.busy       = (state != S_IDLE);
  assign status.held_valid = held_valid;
  assign status.fill       = fill;

  always_comb begin
    place_active = ((state == S_KEY) && (walk != LETTER_J)) ||
                   (fire && (cmd == CMD_KEY_LETTER));
    place_ch     = (state == S_KEY) ? walk : lt;
    place_hit    = (place_ch < ALPHABET_SIZE) ? used[place_ch] : 1'b1;
    place_do     = place_active && !place_hit && (fill < CELLS_FULL);
  end

  always_comb begin
    sh = decrypt ? 3'd4 : 3'd1;
    ra = row_of(pa);
    ca = col_of(pa, ra);
    rb = row_of(place_rdata);
    cb = col_of(place_rdata, rb);
    priority if (ra == rb) begin
      ga_c = cell_of(ra, add_mod5(ca, sh));
      gb_c = cell_of(rb, add_mod5(cb, sh));
    end else if (ca == cb) begin
      ga_c = cell_of(add_mod5(ra, sh), ca);
      gb_c = cell_of(add_mod5(rb, sh), cb);
    end else begin
      ga_c = cell_of(ra, cb);
      gb_c = cell_of(rb, ca);
    end
  end

  always_comb begin
    grid_req.we     = place_do;
    grid_req.waddr  = fill;
    grid_req.wdata  = place_ch;
    grid_req.re     = 1'b0;
    grid_req.raddr  = ga_c;
    place_req.we    = place_do;
    place_req.waddr = place_ch;
    place_req.wdata = fill;
    place_req.re    = 1'b0;
    place_req.raddr = pair_a;
    unique case (state)
      S_PA: begin
        place_req.re = 1'b1;
      end
      S_PB: begin
        place_req.re    = 1'b1;
        place_req.raddr = pair_b;
      end
      S_GA: begin
        grid_req.re = 1'b1;
      end
      S_OA: begin
        grid_req.re    = slot_free;
        grid_req.raddr = gb;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      decrypt     <= 1'b0;
      used        <= '0;
      fill        <= '0;
      held_letter <= '0;
      held_valid  <= 1'b0;
      walk        <= '0;
      second      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        decrypt <= cfg_data;
      end
      if (out_valid && text_out.ready) begin
        out_valid <= 1'b0;
      end
      if (place_do) begin
        used[place_ch] <= 1'b1;
        fill           <= fill + 5'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (fire) begin
            unique case (cmd)
              CMD_BEGIN_KEY: begin
                used       <= '0;
                fill       <= '0;
                held_valid <= 1'b0;
              end
              CMD_KEY_LETTER: begin
              end
              CMD_KEY_END: begin
                walk  <= '0;
                state <= S_KEY;
              end
              CMD_TEXT: begin
                second        <= 1'b0;
                second_letter <= lt;
                priority if (lt_ok && !held_valid) begin
                  held_letter <= lt;
                  held_valid  <= !text_in.last_letter;
                  pair_a      <= lt;
                  pair_b      <= LETTER_X;
                  if (text_in.last_letter) begin
                    state <= S_PA;
                  end
                end else if (lt_ok && (lt == held_letter)) begin
                  pair_a     <= held_letter;
                  pair_b     <= LETTER_X;
                  second     <= text_in.last_letter;
                  held_valid <= !text_in.last_letter;
                  state      <= S_PA;
                end else if (lt_ok) begin
                  pair_a     <= held_letter;
                  pair_b     <= lt;
                  held_valid <= 1'b0;
                  state      <= S_PA;
                end else if (text_in.last_letter && held_valid) begin
                  pair_a     <= held_letter;
                  pair_b     <= LETTER_X;
                  held_valid <= 1'b0;
                  state      <= S_PA;
                end else begin
                end
              end
            endcase
          end
        end
        S_KEY: begin
          walk <= walk + 5'd1;
          if (walk == LETTER_LAST) begin
            state <= S_IDLE;
          end
        end
        S_PA: begin
          state <= S_PB;
        end
        S_PB: begin
          pa    <= place_rdata;
          state <= S_GA;
        end
        S_GA: begin
          gb    <= gb_c;
          state <= S_OA;
        end
        S_OA: begin
          if (slot_free) begin
            out_letter  <= grid_rdata;
            out_run_end <= 1'b0;
            out_valid   <= 1'b1;
            state       <= S_OB;
          end
        end
        S_OB: begin
          if (slot_free) begin
            out_letter  <= grid_rdata;
            out_run_end <= !second;
            out_valid   <= 1'b1;
            if (second) begin
              pair_a <= second_letter;
              pair_b <= LETTER_X;
              second <= 1'b0;
              state  <= S_PA;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

### src/playfair_cipher_stream.sv
// ----------------------------------------------------------------------------
// Playfair cipher stream
// Playfair encryption and decryption over a 5x5 key grid held in memory.
// ----------------------------------------------------------------------------
// Begin key and key letter items are handled in the idle state. On key end
// the controller walks the alphabet one letter per cycle through
// the single write port of the grid and place memories, and takes no item
// meanwhile. A text letter item that closes no digraph is handled in the
// idle state; each digraph adds two place reads and two grid reads, each a
// registered read on the one read port of its memory, and waits while the
// output side stalls. Results leave through a register, so the next item is
// taken while the last result still waits.
module playfair_cipher_stream import pfc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  pfc_in_if.sink    text_in,
  pfc_out_if.source text_out
);
  ram_req_t            grid_req;
  ram_req_t            place_req;
  logic [LETTER_W-1:0] grid_rdata;
  logic [CELL_W-1:0]   place_rdata;
  pfc_status_t         status;

  pfc_ram #(
    .WIDTH(LETTER_W),
    .DEPTH(GRID_CELLS)
  ) u_grid_ram (
    .clk  (clk),
    .we   (grid_req.we),
    .waddr(grid_req.waddr),
    .wdata(grid_req.wdata),
    .re   (grid_req.re),
    .raddr(grid_req.raddr),
    .rdata(grid_rdata)
  );

  pfc_ram #(
    .WIDTH(CELL_W),
    .DEPTH(ALPHABET)
  ) u_place_ram (
    .clk  (clk),
    .we   (place_req.we),
    .waddr(place_req.waddr),
    .wdata(place_req.wdata),
    .re   (place_req.re),
    .raddr(place_req.raddr),
    .rdata(place_rdata)
  );

  pfc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .text_in    (text_in),
    .text_out   (text_out),
    .grid_req   (grid_req),
    .grid_rdata (grid_rdata),
    .place_req  (place_req),
    .place_rdata(place_rdata),
    .status     (status)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    status.fill <= CELLS_FULL)
    else $error("Key grid fill count exceeds the grid size.");

  a_begin_key_clears: assert property (@(posedge clk) disable iff (rst)
    text_in.valid && text_in.ready && (text_in.command == CMD_BEGIN_KEY)
    |=> (status.fill == '0) && !status.held_valid && !status.busy)
    else $error("Begin key item did not clear the key store.");

  a_key_letter_single: assert property (@(posedge clk) disable iff (rst)
    text_in.valid && text_in.ready && (text_in.command == CMD_KEY_LETTER)
    |=> !status.busy && (status.fill - $past(status.fill) <= 5'd1))
    else $error("Key letter item took more than one cycle or one cell.");
`endif
endmodule

### dv/playfair_cipher_stream_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair cipher stream testbench
// Feeds key and text items through the input channel and checks every output
// letter against a cycle-free Playfair predictor. The run has a directed part,
// then random keys and messages in both cipher directions, with random idling
// on both channels.
// ----------------------------------------------------------------------------
module playfair_cipher_stream_tb;
  import pfc_pkg::*;

  localparam int GRID_DIM      = 5;
  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 350;

  typedef struct {
    cmd_t                command;
    logic [LETTER_W-1:0] letter;
    logic                last_letter;
  } cipher_cmd_t;

  typedef struct {
    logic [LETTER_W-1:0] out_letter;
    logic                run_end;
  } cipher_letter_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_data;

  pfc_in_if  text_in ();
  pfc_out_if text_out ();

  playfair_cipher_stream DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .text_in  (text_in),
    .text_out (text_out)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  logic [LETTER_W-1:0] grid_letter [GRID_CELLS];
  logic [CELL_W-1:0]   letter_cell [ALPHABET];
  bit                  letter_placed [ALPHABET];
  int                  cells_filled;
  logic [LETTER_W-1:0] open_letter;
  bit                  open_valid;
  bit                  decrypt_mode;

  cipher_cmd_t    pending_cmds[$];
  cipher_letter_t expected_letters[$];
  bit             failed;
  int             send_idle_pct;
  int             recv_idle_pct;
  int             send_gap;
  int             recv_gap;
  int             quiet_cycles = 0;

  task automatic place_key_letter(input logic [LETTER_W-1:0] c);
    if (c < ALPHABET && !letter_placed[c] && cells_filled < GRID_CELLS) begin
      grid_letter[cells_filled] = c;
      letter_cell[c] = CELL_W'(cells_filled);
      letter_placed[c] = 1'b1;
      cells_filled++;
    end
  endtask

  task automatic encode_digraph(input logic [LETTER_W-1:0] a, input logic [LETTER_W-1:0] b);
    int shift, pa, pb, ra, ca, rb, cb;
    cipher_letter_t first, second;
    shift = decrypt_mode ? GRID_DIM - 1 : 1;
    pa = letter_cell[a];
    pb = letter_cell[b];
    ra = pa / GRID_DIM;
    ca = pa % GRID_DIM;
    rb = pb / GRID_DIM;
    cb = pb % GRID_DIM;
    first.run_end = 1'b0;
    second.run_end = 1'b0;
    if (ra == rb) begin
      first.out_letter = grid_letter[ra * GRID_DIM + (ca + shift) % GRID_DIM];
      second.out_letter = grid_letter[rb * GRID_DIM + (cb + shift) % GRID_DIM];
    end else if (ca == cb) begin
      first.out_letter = grid_letter[((ra + shift) % GRID_DIM) * GRID_DIM + ca];
      second.out_letter = grid_letter[((rb + shift) % GRID_DIM) * GRID_DIM + cb];
    end else begin
      first.out_letter = grid_letter[ra * GRID_DIM + cb];
      second.out_letter = grid_letter[rb * GRID_DIM + ca];
    end
    expected_letters.push_back(first);
    expected_letters.push_back(second);
  endtask

  task automatic predict_cipher(input cipher_cmd_t item);
    logic [LETTER_W-1:0] c;
    int count_before;
    cipher_letter_t tail;
    c = (item.letter == LETTER_J) ? LETTER_I : item.letter;
    count_before = expected_letters.size();
    case (item.command)
      CMD_BEGIN_KEY: begin
        foreach (letter_placed[i]) letter_placed[i] = 1'b0;
        cells_filled = 0;
        open_valid = 1'b0;
      end
      CMD_KEY_LETTER: begin
        place_key_letter(c);
      end
      CMD_KEY_END: begin
        for (int ch = 0; ch < ALPHABET; ch++) begin
          if (ch != LETTER_J) begin
            place_key_letter(LETTER_W'(ch));
          end
        end
      end
      default: begin
        if (c < ALPHABET) begin
          if (!open_valid) begin
            open_letter = c;
            open_valid = 1'b1;
          end else if (c == open_letter) begin
            encode_digraph(open_letter, LETTER_X);
          end else begin
            encode_digraph(open_letter, c);
            open_valid = 1'b0;
          end
        end
        if (item.last_letter && open_valid) begin
          encode_digraph(open_letter, LETTER_X);
          open_valid = 1'b0;
        end
        if (expected_letters.size() > count_before) begin
          tail = expected_letters.pop_back();
          tail.run_end = 1'b1;
          expected_letters.push_back(tail);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    cipher_cmd_t head;
    if (rst) begin
      text_in.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (text_in.valid && text_in.ready) begin
        predict_cipher(pending_cmds.pop_front());
      end
      if (text_in.valid && !text_in.ready) begin
        send_gap = send_gap;
      end else if (send_gap > 0) begin
        send_gap--;
        text_in.valid <= 1'b0;
      end else if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        head = pending_cmds[0];
        text_in.valid <= 1'b1;
        text_in.command <= head.command;
        text_in.letter <= head.letter;
        text_in.last_letter <= head.last_letter;
      end else begin
        text_in.valid <= 1'b0;
        if (pending_cmds.size() != 0) begin
          send_gap = $urandom_range(1, 16) - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cipher_letter_t want;
    if (rst) begin
      text_out.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (text_out.valid && text_out.ready) begin
        if (expected_letters.size() == 0) begin
          $display("%0t: letter with nothing expected: got letter %0d run_end %0b",
                   $time, text_out.out_letter, text_out.run_end);
          failed = 1'b1;
        end else begin
          want = expected_letters.pop_front();
          if (text_out.out_letter !== want.out_letter || text_out.run_end !== want.run_end) begin
            $display("%0t: expected letter %0d run_end %0b, got letter %0d run_end %0b",
                     $time, want.out_letter, want.run_end, text_out.out_letter,
                     text_out.run_end);
            failed = 1'b1;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        text_out.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap = $urandom_range(1, 16) - 1;
        text_out.ready <= 1'b0;
      end else begin
        text_out.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (text_in.valid && text_in.ready) || (text_out.valid && text_out.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic queue_cmd(input cmd_t command, input logic [LETTER_W-1:0] letter,
                           input logic last_letter);
    cipher_cmd_t item;
    item.command = command;
    item.letter = letter;
    item.last_letter = last_letter;
    pending_cmds.push_back(item);
  endtask

  task automatic drain_and_settle();
    while (pending_cmds.size() != 0 || expected_letters.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_decrypt(input bit value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    decrypt_mode = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random_phase(output int count);
    int key_len, msg_len, offset;
    logic [LETTER_W-1:0] prev, ch;
    bit have_prev;
    count = 0;
    queue_cmd(CMD_BEGIN_KEY, LETTER_W'($urandom), 1'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      offset = $urandom_range(0, ALPHABET - 1);
      for (int i = 0; i < ALPHABET; i++) begin
        queue_cmd(CMD_KEY_LETTER, LETTER_W'((i * 7 + offset) % ALPHABET), 1'($urandom));
      end
      queue_cmd(CMD_KEY_LETTER, LETTER_W'($urandom), 1'($urandom));
      count += ALPHABET + 1;
    end else begin
      key_len = $urandom_range(0, 12);
      for (int i = 0; i < key_len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          ch = LETTER_W'($urandom_range(ALPHABET, 31));
        end else begin
          ch = LETTER_W'($urandom_range(0, ALPHABET - 1));
        end
        queue_cmd(CMD_KEY_LETTER, ch, 1'($urandom));
      end
      count += key_len;
    end
    queue_cmd(CMD_KEY_END, LETTER_W'($urandom), 1'($urandom));
    count += 2;
    msg_len = $urandom_range(1, 16);
    have_prev = 1'b0;
    prev = '0;
    for (int i = 0; i < msg_len; i++) begin
      if (have_prev && $urandom_range(0, 3) == 0) begin
        ch = prev;
      end else if ($urandom_range(0, 5) == 0) begin
        ch = LETTER_X;
      end else if ($urandom_range(0, 19) == 0) begin
        ch = LETTER_W'($urandom_range(ALPHABET, 31));
      end else begin
        ch = LETTER_W'($urandom_range(0, ALPHABET - 1));
      end
      queue_cmd(CMD_TEXT, ch, (i == msg_len - 1) || ($urandom_range(0, 19) == 0));
      prev = ch;
      have_prev = 1'b1;
      count++;
      if ($urandom_range(0, 24) == 0) begin
        queue_cmd(cmd_t'($urandom_range(0, 3)), LETTER_W'($urandom), 1'($urandom));
        count++;
      end
    end
  endtask

  initial begin
    int sent, phase_items, phase_no;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    text_in.valid = 1'b0;
    text_in.command = CMD_BEGIN_KEY;
    text_in.letter = '0;
    text_in.last_letter = 1'b0;
    text_out.ready = 1'b0;
    foreach (letter_placed[i]) letter_placed[i] = 1'b0;
    cells_filled = 0;
    open_letter = '0;
    open_valid = 1'b0;
    decrypt_mode = 1'b0;
    failed = 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 10;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_decrypt(1'b0);
    queue_cmd(CMD_BEGIN_KEY, 5'd31, 1'b1);
    queue_cmd(CMD_KEY_LETTER, 5'd15, 1'b0);
    queue_cmd(CMD_KEY_LETTER, 5'd11, 1'b0);
    queue_cmd(CMD_KEY_LETTER, 5'd0, 1'b0);
    queue_cmd(CMD_KEY_LETTER, 5'd24, 1'b0);
    queue_cmd(CMD_KEY_LETTER, LETTER_J, 1'b0);
    queue_cmd(CMD_KEY_LETTER, 5'd31, 1'b0);
    queue_cmd(CMD_KEY_LETTER, 5'd5, 1'b0);
    queue_cmd(CMD_KEY_LETTER, LETTER_I, 1'b0);
    queue_cmd(CMD_KEY_END, 5'd0, 1'b0);
    queue_cmd(CMD_TEXT, LETTER_LAST, 1'b0);
    queue_cmd(CMD_TEXT, 5'd0, 1'b0);
    queue_cmd(CMD_TEXT, LETTER_X, 1'b0);
    queue_cmd(CMD_TEXT, LETTER_X, 1'b0);
    queue_cmd(CMD_TEXT, 5'd11, 1'b0);
    queue_cmd(CMD_TEXT, 5'd11, 1'b0);
    queue_cmd(CMD_TEXT, 5'd11, 1'b1);
    queue_cmd(CMD_TEXT, 5'd4, 1'b0);
    queue_cmd(CMD_TEXT, 5'd28, 1'b1);
    queue_cmd(CMD_TEXT, LETTER_J, 1'b1);
    queue_cmd(CMD_TEXT, 5'd31, 1'b0);
    queue_cmd(CMD_TEXT, 5'd0, 1'b1);
    drain_and_settle();

    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent > RANDOM_ITEMS * 4 / 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = $urandom_range(0, 2) * 15;
        recv_idle_pct = $urandom_range(0, 2) * 15;
      end
      write_decrypt(phase_no == 0 ? 1'b1 : 1'($urandom));
      queue_random_phase(phase_items);
      sent += phase_items;
      phase_no++;
      drain_and_settle();
    end

    if (!failed) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
